// File: hw/rtl/l2_distance_top_k_ranker_top_defines.svh
// Assertion macros shared by the ranker RTL.
// Each macro takes a label and checks on the rising edge of clk, off during reset.
`ifndef L2_DISTANCE_TOP_K_RANKER_TOP_DEFINES_SVH
`define L2_DISTANCE_TOP_K_RANKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define L2TK_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("l2tk assertion failed");

// Next-cycle implication.
`define L2TK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("l2tk assertion failed");

`endif

// File: hw/rtl/l2tk_pkg.sv
// ----------------------------------------------------------------------------
// l2tk_pkg
// Types and fixed constants of the squared-L2 top-K ranker.
// ----------------------------------------------------------------------------
package l2tk_pkg;

	localparam int VECTOR_DIM  = 128;
	localparam int STORE_DEPTH = 128;

	localparam int MODE_W  = 2;
	localparam int DIM_W   = 7;
	localparam int COMP_W  = 8;
	localparam int ID_W    = 20;
	localparam int SQ_W    = 16;
	localparam int DIST_W  = 23;
	localparam int RANK_W  = 4;
	localparam int RWIDE_W = 7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CAND   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

	localparam logic [DIST_W-1:0] SUM_MAX = {DIST_W{1'b1}};

	typedef logic [MODE_W-1:0] mode_t;

	// One operation for the back end: a candidate component or a finish.
	typedef struct packed {
		logic            finish;
		logic            last;
		logic [SQ_W-1:0] sq;
		logic [ID_W-1:0] id;
	} l2tk_op_t;

endpackage

// File: hw/rtl/l2tk_front.sv
// ----------------------------------------------------------------------------
// l2tk_front
// Accepts input words, keeps the query store and squares component differences.
// ----------------------------------------------------------------------------
module l2tk_front
	import l2tk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mode_t             mode,
	input  logic [DIM_W-1:0]  dim_index,
	input  logic [COMP_W-1:0] component,
	input  logic [ID_W-1:0]   candidate_id,
	input  logic              last_dim,
	output logic              push_valid,
	input  logic              push_ready,
	output l2tk_op_t          push_op
);

	logic [COMP_W-1:0] store_q [STORE_DEPTH];

	logic              valid_s1;
	mode_t             mode_s1;
	logic [COMP_W-1:0] comp_s1;
	logic [COMP_W-1:0] qry_s1;
	logic [ID_W-1:0]   id_s1;
	logic              last_s1;
	logic              dim_ok_s1;

	logic              accept;
	logic              dim_ok;
	logic              need_push;
	logic              s1_free;
	logic [COMP_W-1:0] diff;
	logic [SQ_W-1:0]   sq;

	assign dim_ok    = 32'(dim_index) < VECTOR_DIM;
	assign need_push = valid_s1 && (mode_s1 == MODE_CAND || mode_s1 == MODE_FINISH);
	assign s1_free   = !valid_s1 || !need_push || push_ready;
	assign in_ready  = s1_free;
	assign accept    = in_valid && in_ready;

	// query store: write on load, registered read for candidates
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_LOAD && dim_ok) begin
			store_q[dim_index] <= component;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qry_s1    <= store_q[dim_index];
			mode_s1   <= mode;
			comp_s1   <= component;
			id_s1     <= candidate_id;
			last_s1   <= last_dim;
			dim_ok_s1 <= dim_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_free) begin
			valid_s1 <= 1'b0;
		end
	end

	assign diff = (comp_s1 > qry_s1) ? (comp_s1 - qry_s1) : (qry_s1 - comp_s1);
	assign sq   = SQ_W'(diff) * SQ_W'(diff);

	assign push_valid     = need_push;
	assign push_op.finish = (mode_s1 == MODE_FINISH);
	assign push_op.last   = last_s1;
	assign push_op.sq     = dim_ok_s1 ? sq : '0;
	assign push_op.id     = id_s1;

endmodule

// File: hw/rtl/l2tk_queue.sv
// ----------------------------------------------------------------------------
// l2tk_queue
// Short FIFO of operations between the front and the back end.
// ----------------------------------------------------------------------------
`include "l2_distance_top_k_ranker_top_defines.svh"

module l2tk_queue
	import l2tk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  l2tk_op_t push_op,
	output logic     pop_valid,
	input  logic     pop_ready,
	output l2tk_op_t pop_op
);

	l2tk_op_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   head_q;
	logic [QPTR_W-1:0]   tail_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_op     = entry_q[head_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[tail_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`L2TK_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))
	`L2TK_ASSERT_NEXT(a_cnt_grow, do_push && !do_pop, cnt_q == QCNT_W'($past(cnt_q) + 1'b1))

endmodule

// File: hw/rtl/l2tk_back.sv
// ----------------------------------------------------------------------------
// l2tk_back
// Accumulates distances, keeps the sorted top-K list and emits it on finish.
// ----------------------------------------------------------------------------
`include "l2_distance_top_k_ranker_top_defines.svh"

module l2tk_back
	import l2tk_pkg::*;
#(
	parameter int TOP_K = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  l2tk_op_t          pop_op,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RANK_W-1:0] rank,
	output logic [ID_W-1:0]   neighbor_id,
	output logic [DIST_W-1:0] distance,
	output logic              found,
	output logic              last_rank
);

	localparam int RCNT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                state_q;
	logic [RCNT_W-1:0]   rcnt_q;
	logic [DIST_W-1:0]   psum_q;

	logic [DIST_W-1:0]   best_dist_q [TOP_K];
	logic [ID_W-1:0]     best_id_q   [TOP_K];
	logic [TOP_K-1:0]    best_val_q;

	logic [DIST_W-1:0]   best_dist_d [TOP_K];
	logic [ID_W-1:0]     best_id_d   [TOP_K];
	logic [TOP_K-1:0]    best_val_d;

	logic                out_valid_q;
	logic [RANK_W-1:0]   out_rank_q;
	logic [ID_W-1:0]     out_id_q;
	logic [DIST_W-1:0]   out_dist_q;
	logic                out_found_q;
	logic                out_last_q;

	logic                do_pop;
	logic                load_out;
	logic                rank_last;
	logic [DIST_W:0]     sum_wide;
	logic [DIST_W-1:0]   sum_new;
	logic [TOP_K-1:0]    beats;
	logic [RWIDE_W-1:0]  rank_wide;

	assign pop_ready = (state_q == ST_RUN);
	assign do_pop    = pop_valid && pop_ready;
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign rank_last = (rcnt_q == RCNT_W'(TOP_K - 1));
	assign rank_wide = RWIDE_W'(rcnt_q);

	// saturate the running sum at the top of its range
	assign sum_wide = {1'b0, psum_q} + (DIST_W + 1)'(pop_op.sq);
	assign sum_new  = sum_wide[DIST_W] ? SUM_MAX : sum_wide[DIST_W-1:0];

	always_comb begin
		for (int p = 0; p < TOP_K; p++) begin
			beats[p] = !best_val_q[p] || (sum_new < best_dist_q[p]);
		end
		best_dist_d = best_dist_q;
		best_id_d   = best_id_q;
		best_val_d  = best_val_q;
		if (do_pop && !pop_op.finish && pop_op.last) begin
			// parallel compare and shift: entries behind the new one move down
			if (beats[0]) begin
				best_dist_d[0] = sum_new;
				best_id_d[0]   = pop_op.id;
				best_val_d[0]  = 1'b1;
			end
			for (int p = 1; p < TOP_K; p++) begin
				if (beats[p]) begin
					if (beats[p-1]) begin
						best_dist_d[p] = best_dist_q[p-1];
						best_id_d[p]   = best_id_q[p-1];
						best_val_d[p]  = best_val_q[p-1];
					end else begin
						best_dist_d[p] = sum_new;
						best_id_d[p]   = pop_op.id;
						best_val_d[p]  = 1'b1;
					end
				end
			end
		end else if (load_out) begin
			// drain toward rank zero, refill the tail with empty slots
			for (int p = 0; p < TOP_K - 1; p++) begin
				best_dist_d[p] = best_dist_q[p+1];
				best_id_d[p]   = best_id_q[p+1];
				best_val_d[p]  = best_val_q[p+1];
			end
			best_dist_d[TOP_K-1] = SUM_MAX;
			best_id_d[TOP_K-1]   = '0;
			best_val_d[TOP_K-1]  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		best_dist_q <= best_dist_d;
		best_id_q   <= best_id_d;
		if (load_out) begin
			out_rank_q  <= rank_wide[RANK_W-1:0];
			out_id_q    <= best_val_q[0] ? best_id_q[0] : '0;
			out_dist_q  <= best_val_q[0] ? best_dist_q[0] : '0;
			out_found_q <= best_val_q[0];
			out_last_q  <= rank_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			rcnt_q      <= '0;
			psum_q      <= '0;
			best_val_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			best_val_q <= best_val_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (do_pop) begin
						if (pop_op.finish) begin
							state_q <= ST_EMIT;
							rcnt_q  <= '0;
							psum_q  <= '0;
						end else if (pop_op.last) begin
							psum_q <= '0;
						end else begin
							psum_q <= sum_new;
						end
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						rcnt_q <= rcnt_q + 1'b1;
						if (rank_last) begin
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign rank        = out_rank_q;
	assign neighbor_id = out_id_q;
	assign distance    = out_dist_q;
	assign found       = out_found_q;
	assign last_rank   = out_last_q;

	`L2TK_ASSERT_IMPLY(a_valid_prefix, 1'b1, ((best_val_q >> 1) & ~best_val_q) == '0)
	`L2TK_ASSERT_NEXT(a_emit_clears, load_out && rank_last, best_val_q == '0)

endmodule

// File: hw/rtl/l2_distance_top_k_ranker_top.sv
// ----------------------------------------------------------------------------
// l2_distance_top_k_ranker_top
// Exact squared-L2 brute-force k-NN ranker keeping a sorted top-K list.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle for load and candidate components while the queue has room.
// A candidate's distance enters the list after its last component passes the front stage and the queue.
// A finish word emits TOP_K result words, one per cycle while out_ready is high, once the finish has
// passed the front stage and the queue; the back end takes no queue entries while the list drains.
// Reset: list empty, running sum zero, queue empty; query store undefined.
// ----------------------------------------------------------------------------
module l2_distance_top_k_ranker_top
	import l2tk_pkg::*;
#(
	parameter int TOP_K = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [DIM_W-1:0]  dim_index,
	input  logic [COMP_W-1:0] component,
	input  logic [ID_W-1:0]   candidate_id,
	input  logic              last_dim,
	// result words
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RANK_W-1:0] rank,
	output logic [ID_W-1:0]   neighbor_id,
	output logic [DIST_W-1:0] distance,
	output logic              found,
	output logic              last_rank
);

	// front to queue
	logic     push_valid;
	logic     push_ready;
	l2tk_op_t push_op;

	// queue to back end
	logic     pop_valid;
	logic     pop_ready;
	l2tk_op_t pop_op;

	// Front: take the word, update or read the query store, square the difference.
	// Load and ignored-mode words end here; candidate and finish words move on.
	l2tk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.dim_index    (dim_index),
		.component    (component),
		.candidate_id (candidate_id),
		.last_dim     (last_dim),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_op      (push_op)
	);

	// Queue: absorb words while the back end drains a finished list.
	l2tk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	// Back end: accumulate, insert on the last component, emit on finish.
	l2tk_back #(
		.TOP_K (TOP_K)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_op      (pop_op),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rank        (rank),
		.neighbor_id (neighbor_id),
		.distance    (distance),
		.found       (found),
		.last_rank   (last_rank)
	);

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the squared-L2 top-K ranker.
// Drive load, candidate, finish and ignored words through the input
// handshake while the result side stalls at random. An in-bench ranker
// keeps its own query store, running sum and sorted list, and queues the
// rank words that each finish must produce. Each result word is checked
// field by field against the oldest queued rank word.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import l2tk_pkg::*;

	localparam int    K         = 10;
	localparam mode_t MODE_SKIP = 2'd3;	// spare code, the block ignores it
	localparam int    RAND_END  = 400;	// counted items at which random stimulus stops
	localparam int    CALM_FROM = 360;	// no idling on either side past this count

	typedef struct {
		mode_t             mode;
		logic [DIM_W-1:0]  dim;
		logic [COMP_W-1:0] comp;
		logic [ID_W-1:0]   id;
		logic              last;
	} in_word_t;

	typedef struct {
		logic [RANK_W-1:0] rank;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] sq_dist;
		logic              found;
		logic              last;
	} rank_word_t;

	// One directed step. Typed rows are finishes whose list is known by
	// inspection: rank 0 as given, every other rank empty.
	typedef struct {
		in_word_t          w;
		bit                typed;
		logic [ID_W-1:0]   id0;
		logic [DIST_W-1:0] dist0;
		logic              found0;
	} step_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [MODE_W-1:0] mode;
	logic [DIM_W-1:0]  dim_index;
	logic [COMP_W-1:0] component;
	logic [ID_W-1:0]   candidate_id;
	logic              last_dim;
	logic              out_valid;
	logic              out_ready;
	logic [RANK_W-1:0] rank;
	logic [ID_W-1:0]   neighbor_id;
	logic [DIST_W-1:0] distance;
	logic              found;
	logic              last_rank;

	// Ranker state of the bench.
	logic [COMP_W-1:0] q_vec [STORE_DEPTH];
	bit                q_set [STORE_DEPTH];
	int                set_dims[$];	// query dimensions written since reset
	logic [DIST_W-1:0] run_sum;
	logic [DIST_W-1:0] top_dist [K];
	logic [ID_W-1:0]   top_id [K];
	bit                top_used [K];
	rank_word_t        ranked_q[$];	// rank words still owed by the block

	int errors;
	int items;
	bit calm;

	l2_distance_top_k_ranker_top #(
		.TOP_K(K)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.dim_index(dim_index),
		.component(component),
		.candidate_id(candidate_id),
		.last_dim(last_dim),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rank(rank),
		.neighbor_id(neighbor_id),
		.distance(distance),
		.found(found),
		.last_rank(last_rank)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic in_word_t mk(mode_t m, int d, int c, int cid, bit l);
		in_word_t w;
		w.mode = m;
		w.dim  = d[DIM_W-1:0];
		w.comp = c[COMP_W-1:0];
		w.id   = cid[ID_W-1:0];
		w.last = l;
		return w;
	endfunction

	// Empty the sorted list: empty slots rank behind every distance.
	task automatic clear_top();
		for (int i = 0; i < K; i++) begin
			top_dist[i] = SUM_MAX;
			top_id[i]   = '0;
			top_used[i] = 1'b0;
		end
	endtask

	// Insert a closed candidate; ties keep the entries already held.
	task automatic insert_dist(logic [DIST_W-1:0] d, logic [ID_W-1:0] cid);
		int p;
		p = K - 1;
		if (top_used[p] && d >= top_dist[p])
			return;
		while (p > 0 && (!top_used[p-1] || d < top_dist[p-1])) begin
			top_dist[p] = top_dist[p-1];
			top_id[p]   = top_id[p-1];
			top_used[p] = top_used[p-1];
			p--;
		end
		top_dist[p] = d;
		top_id[p]   = cid;
		top_used[p] = 1'b1;
	endtask

	// Advance the bench ranker by one accepted word; queue the rank words
	// of a finish only when post is set.
	task automatic advance_ranker(in_word_t w, bit post);
		int unsigned diff;
		int unsigned acc;
		rank_word_t  rw;
		case (w.mode)
			MODE_LOAD: begin
				if (w.dim < VECTOR_DIM) begin
					q_vec[w.dim] = w.comp;
					if (!q_set[w.dim]) begin
						q_set[w.dim] = 1'b1;
						set_dims.push_back(w.dim);
					end
				end
			end
			MODE_CAND: begin
				if (w.dim < VECTOR_DIM) begin
					diff = (w.comp > q_vec[w.dim]) ? w.comp - q_vec[w.dim]
						: q_vec[w.dim] - w.comp;
					acc = run_sum + diff * diff;
					// saturate rather than wrap
					run_sum = (acc > SUM_MAX) ? SUM_MAX : acc[DIST_W-1:0];
				end
				if (w.last) begin
					insert_dist(run_sum, w.id);
					run_sum = '0;
				end
			end
			MODE_FINISH: begin
				if (post) begin
					for (int r = 0; r < K; r++) begin
						rw.rank    = r[RANK_W-1:0];
						rw.id      = top_used[r] ? top_id[r] : '0;
						rw.sq_dist = top_used[r] ? top_dist[r] : '0;
						rw.found   = top_used[r];
						rw.last    = (r == K - 1);
						ranked_q.push_back(rw);
					end
				end
				clear_top();
				run_sum = '0;
			end
			default: ;	// spare code: no effect
		endcase
	endtask

	// Present one word and hold it until accepted. The handshake is sampled
	// at the falling edge, where everything is settled, and the word is
	// taken at the next rising edge. Valid stays high on return; the caller
	// drops it before any pause of its own.
	task automatic send_word(in_word_t w, bit post);
		bit took;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= w.mode;
		dim_index    <= w.dim;
		component    <= w.comp;
		candidate_id <= w.id;
		last_dim     <= w.last;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		advance_ranker(w, post);
		if (w.mode != MODE_SKIP)
			items++;
	endtask

	// Result side: stall in random bursts, none started while calm.
	initial begin : drain_side
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check every result word taken at the next rising edge against the
	// oldest owed rank word.
	always @(negedge clk) begin : check_results
		rank_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ranked_q.size() == 0) begin
				$error("unexpected result word: rank %0d id %0d distance %0d",
					rank, neighbor_id, distance);
				errors++;
			end else begin
				want = ranked_q.pop_front();
				if (rank !== want.rank) begin
					$error("rank: expected %0d, got %0d", want.rank, rank);
					errors++;
				end
				if (neighbor_id !== want.id) begin
					$error("neighbor_id: expected %0d, got %0d", want.id, neighbor_id);
					errors++;
				end
				if (distance !== want.sq_dist) begin
					$error("distance: expected %0d, got %0d", want.sq_dist, distance);
					errors++;
				end
				if (found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, found);
					errors++;
				end
				if (last_rank !== want.last) begin
					$error("last_rank: expected %0d, got %0d", want.last, last_rank);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		step_row_t  rows[$];
		rank_word_t rw;
		in_word_t   w;
		int         ncand;
		int         len;
		int         nload;
		logic [ID_W-1:0] cid;

		errors = 0;
		items  = 0;
		calm   = 1'b0;
		run_sum = '0;
		clear_top();
		foreach (q_set[i])
			q_set[i] = 1'b0;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		mode         <= MODE_LOAD;
		dim_index    <= '0;
		component    <= '0;
		candidate_id <= '0;
		last_dim     <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps.
		// Finish straight after reset: every rank empty.
		rows.push_back('{mk(MODE_FINISH, 0, 0, 0, 0), 1, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_LOAD, 0, 255, 0, 0), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_LOAD, 127, 0, 0, 0), 0, 20'd0, 23'd0, 1'b0});
		// One candidate at the largest per-component difference, highest id.
		rows.push_back('{mk(MODE_CAND, 0, 0, 'hFFFFF, 1), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_FINISH, 0, 0, 0, 0), 1, 20'hFFFFF, 23'd65025, 1'b1});
		rows.push_back('{mk(MODE_CAND, 127, 255, 0, 1), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_CAND, 0, 255, 1, 1), 0, 20'd0, 23'd0, 1'b0});
		// Two-component candidate that ties the id 0 entry: it ranks behind.
		rows.push_back('{mk(MODE_CAND, 0, 0, 2, 0), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_CAND, 127, 0, 3, 1), 0, 20'd0, 23'd0, 1'b0});
		// Spare mode with every field loaded: ignored.
		rows.push_back('{mk(MODE_SKIP, 127, 255, 'hFFFFF, 1), 0, 20'd0, 23'd0, 1'b0});
		// Only the id on the last component counts.
		rows.push_back('{mk(MODE_CAND, 0, 128, 'hFFFFF, 0), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_CAND, 127, 128, 5, 1), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_FINISH, 0, 0, 0, 0), 0, 20'd0, 23'd0, 1'b0});
		// Overfill the list, then offer a tie with the last entry: rejected.
		for (int i = 0; i <= 10; i++)
			rows.push_back('{mk(MODE_CAND, 0, 20 * i, 16 + i, 1), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_CAND, 0, 20, 99, 1), 0, 20'd0, 23'd0, 1'b0});
		rows.push_back('{mk(MODE_FINISH, 0, 0, 0, 0), 0, 20'd0, 23'd0, 1'b0});

		foreach (rows[i]) begin
			send_word(rows[i].w, !rows[i].typed);
			if (rows[i].typed) begin
				for (int r = 0; r < K; r++) begin
					rw.rank    = r[RANK_W-1:0];
					rw.id      = (r == 0) ? rows[i].id0 : '0;
					rw.sq_dist = (r == 0) ? rows[i].dist0 : '0;
					rw.found   = (r == 0) ? rows[i].found0 : 1'b0;
					rw.last    = (r == K - 1);
					ranked_q.push_back(rw);
				end
			end
		end

		// Hold the sender until the list has drained completely.
		in_valid <= 1'b0;
		while (ranked_q.size() != 0) @(posedge clk);

		// Saturate the running sum by repeating one dimension at the
		// largest difference, then emit the list.
		send_word(mk(MODE_LOAD, 5, 0, 0, 0), 1);
		for (int j = 0; j < 130; j++)
			send_word(mk(MODE_CAND, 5, 255, $urandom(), j == 129), 1);
		send_word(mk(MODE_FINISH, $urandom(), $urandom(), $urandom(),
			$urandom_range(0, 1)), 1);

		// Write the whole query once; afterwards every dimension is legal.
		for (int d = 0; d < STORE_DEPTH; d++)
			send_word(mk(MODE_LOAD, d, $urandom_range(0, 255), $urandom(),
				$urandom_range(0, 1)), 1);

		// Random queries: refresh a few query components, stream candidates
		// made of components on written dimensions only, finish.
		while (items < RAND_END) begin
			calm = (items >= CALM_FROM) || ($urandom_range(0, 3) == 0);
			nload = $urandom_range(0, 6);
			for (int j = 0; j < nload; j++)
				send_word(mk(MODE_LOAD, $urandom_range(0, STORE_DEPTH - 1),
					($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
						: $urandom_range(0, 255),
					$urandom(), $urandom_range(0, 1)), 1);
			ncand = $urandom_range(0, 14);
			for (int c = 0; c < ncand; c++) begin
				cid = ID_W'($urandom());
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 4);
				for (int j = 0; j < len; j++) begin
					// drop in noise: spare-mode words and stray query writes
					if ($urandom_range(0, 11) == 0)
						send_word(mk(MODE_SKIP, $urandom(), $urandom(), $urandom(),
							$urandom_range(0, 1)), 1);
					if ($urandom_range(0, 19) == 0)
						send_word(mk(MODE_LOAD, $urandom_range(0, STORE_DEPTH - 1),
							$urandom_range(0, 255), $urandom(), 0), 1);
					w = mk(MODE_CAND, set_dims[$urandom_range(0, set_dims.size() - 1)],
						($urandom_range(0, 3) == 0) ? 255 * $urandom_range(0, 1)
							: $urandom_range(0, 255),
						$urandom(), j == len - 1);
					if (w.last)
						w.id = cid;
					send_word(w, 1);
				end
			end
			send_word(mk(MODE_FINISH, $urandom(), $urandom(), $urandom(),
				$urandom_range(0, 1)), 1);
			if (!calm && $urandom_range(0, 4) == 0) begin
				in_valid <= 1'b0;
				while (ranked_q.size() != 0) @(posedge clk);
			end
		end

		// Drain, then give stray words time to show up.
		calm = 1'b1;
		in_valid <= 1'b0;
		while (ranked_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && ranked_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/l2tk_pkg.sv
hw/rtl/l2tk_front.sv
hw/rtl/l2tk_queue.sv
hw/rtl/l2tk_back.sv
hw/rtl/l2_distance_top_k_ranker_top.sv
verif/tb_top.sv
